### rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and fixed widths of the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // channel byte width
    localparam int CH_W     = 8;
    // hue field width on the port
    localparam int HUE_W    = 15;
    // integer bits needed to hold 360 degrees
    localparam int HUE_INT_W = 9;
    // width of the sector numerator before fractional scaling (< 360*255)
    localparam int T_W      = 17;
    // saturation numerator 255*delta + max/2
    localparam int SNUM_W   = 16;
    // saturation quotient bits
    localparam int SAT_QW   = 8;

    // pixel sector multipliers, in degrees
    localparam logic [HUE_INT_W-1:0] BASE_RED      = 9'd0;
    localparam logic [HUE_INT_W-1:0] BASE_RED_WRAP = 9'd360;
    localparam logic [HUE_INT_W-1:0] BASE_GREEN    = 9'd120;
    localparam logic [HUE_INT_W-1:0] BASE_BLUE     = 9'd240;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_word_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_word_t;

    // divider operands that do not depend on the hue scaling
    typedef struct packed {
        logic              grey;
        logic [CH_W-1:0]   delta;
        logic [CH_W-1:0]   max_ch;
        logic [SNUM_W-1:0] sat_num;
    } div_info_t;

endpackage

### rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Classifies a pixel (max, min, sector) and forms the divider numerators.
// ----------------------------------------------------------------------------
module rhc_front
    import rhc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pixel_word_t                         pixel,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    output logic [T_W+HUE_FRAC_BITS-1:0]        hue_num,
    output div_info_t                           info,
    output logic                                info_valid,
    input  logic                                info_ready
);

    localparam int HNUM_W = T_W + HUE_FRAC_BITS;

    logic [CH_W-1:0]      max_ch;
    logic [CH_W-1:0]      min_ch;
    logic [CH_W-1:0]      delta;
    logic [HUE_INT_W-1:0] base;
    logic signed [CH_W:0] diff;
    logic [T_W-1:0]       base_prod;
    logic signed [T_W+1:0] t_s;
    logic [T_W-1:0]       t;

    logic                 valid_reg;
    logic [HNUM_W-1:0]    hue_num_reg;
    logic [HNUM_W-1:0]    hue_num_next;
    div_info_t            info_reg;
    div_info_t            info_next;
    logic                 load;

    // max, min and sector choice; red wins ties, then green
    always_comb
    begin
        max_ch = (pixel.red > pixel.green) ? pixel.red : pixel.green;
        if (pixel.blue > max_ch)
        begin
            max_ch = pixel.blue;
        end
        min_ch = (pixel.red < pixel.green) ? pixel.red : pixel.green;
        if (pixel.blue < min_ch)
        begin
            min_ch = pixel.blue;
        end
        delta = max_ch - min_ch;

        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
        begin
            base = (pixel.green >= pixel.blue) ? BASE_RED : BASE_RED_WRAP;
            diff = signed'({1'b0, pixel.green}) - signed'({1'b0, pixel.blue});
        end
        else if (pixel.green >= pixel.blue)
        begin
            base = BASE_GREEN;
            diff = signed'({1'b0, pixel.blue}) - signed'({1'b0, pixel.red});
        end
        else
        begin
            base = BASE_BLUE;
            diff = signed'({1'b0, pixel.red}) - signed'({1'b0, pixel.green});
        end
    end

    // sector numerator, never negative
    always_comb
    begin
        base_prod = T_W'(base) * T_W'(delta);
        t_s       = signed'({2'b00, base_prod}) + (19'(diff) * 19'sd60);
        t         = t_s[T_W-1:0];

        hue_num_next = (HNUM_W'(t) << HUE_FRAC_BITS) + HNUM_W'(delta[CH_W-1:1]);

        info_next.grey    = (delta == '0);
        info_next.delta   = delta;
        info_next.max_ch  = max_ch;
        info_next.sat_num = (SNUM_W'(delta) * SNUM_W'(255)) + SNUM_W'(max_ch[CH_W-1:1]);
    end

    assign pixel_ready = !valid_reg || info_ready;
    assign load        = pixel_valid && pixel_ready;

    // front register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            valid_reg <= pixel_valid;
        end
    end

    // front register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hue_num_reg <= hue_num_next;
            info_reg    <= info_next;
        end
    end

    assign hue_num    = hue_num_reg;
    assign info       = info_reg;
    assign info_valid = valid_reg;

endmodule

### rtl/rhc_queue.sv
// ----------------------------------------------------------------------------
// rhc_queue
// Two-entry queue that decouples the classifier from the divider pipeline.
// ----------------------------------------------------------------------------
module rhc_queue
    import rhc_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              wr_valid,
    output logic              wr_ready,
    output logic [DATA_W-1:0] rd_data,
    output logic              rd_valid,
    input  logic              rd_ready
);

    logic [DATA_W-1:0] mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Pipelined restoring divider for hue and saturation, one hue quotient bit per stage and one
// saturation bit in each of the last SAT_QW stages, followed by the output register.
// ----------------------------------------------------------------------------
module rhc_back
    import rhc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [T_W+HUE_FRAC_BITS-1:0]    hue_num,
    input  div_info_t                       info,
    input  logic                            info_valid,
    output logic                            info_ready,
    output hsv_word_t                       hsv,
    output logic                            hsv_valid,
    input  logic                            hsv_ready
);

    localparam int HNUM_W    = T_W + HUE_FRAC_BITS;
    localparam int HQW       = HUE_INT_W + HUE_FRAC_BITS;
    localparam int SAT_FIRST = HQW - SAT_QW;
    localparam int HX_W      = (HQW > HUE_W) ? HQW : HUE_W;
    localparam logic [HQW-1:0] HUE_FULL = HQW'(360 << HUE_FRAC_BITS);

    // stage registers
    logic              v_reg    [HQW];
    logic [HNUM_W-1:0] hrem_reg [HQW];
    logic [HQW-1:0]    hq_reg   [HQW];
    logic [SNUM_W-1:0] srem_reg [HQW];
    logic [SAT_QW-1:0] sq_reg   [HQW];
    logic [CH_W-1:0]   hd_reg   [HQW];
    logic [CH_W-1:0]   sd_reg   [HQW];
    logic              grey_reg [HQW];

    // stage sources and flow control
    logic [HNUM_W-1:0] hrem_src [HQW];
    logic [HQW-1:0]    hq_src   [HQW];
    logic [SNUM_W-1:0] srem_src [HQW];
    logic [SAT_QW-1:0] sq_src   [HQW];
    logic [CH_W-1:0]   hd_src   [HQW];
    logic [CH_W-1:0]   sd_src   [HQW];
    logic              grey_src [HQW];
    logic              adv      [HQW];
    logic              drain    [HQW];
    logic              free     [HQW];

    logic              out_valid_reg;
    hsv_word_t         out_reg;
    hsv_word_t         out_next;
    logic              out_free;
    logic              out_load;
    logic [HQW-1:0]    hue_q;
    logic [HX_W-1:0]   hue_x;

    assign out_free   = !out_valid_reg || hsv_ready;
    assign out_load   = v_reg[HQW-1] && out_free;
    assign info_ready = free[0];

    genvar s;
    generate
        for (s = 0; s < HQW; s++)
        begin : g_stage
            localparam int K = HQW - 1 - s;

            logic [HNUM_W-1:0] hds;
            logic              hbit;
            logic [HNUM_W-1:0] hrem_next;
            logic [HQW-1:0]    hq_next;
            logic [SNUM_W-1:0] srem_next;
            logic [SAT_QW-1:0] sq_next;

            // stage inputs
            if (s == 0)
            begin : g_head
                assign hrem_src[s] = hue_num;
                assign hq_src[s]   = '0;
                assign srem_src[s] = info.sat_num;
                assign sq_src[s]   = '0;
                assign hd_src[s]   = info.delta;
                assign sd_src[s]   = info.max_ch;
                assign grey_src[s] = info.grey;
                assign adv[s]      = info_valid && free[s];
            end
            else
            begin : g_body
                assign hrem_src[s] = hrem_reg[s-1];
                assign hq_src[s]   = hq_reg[s-1];
                assign srem_src[s] = srem_reg[s-1];
                assign sq_src[s]   = sq_reg[s-1];
                assign hd_src[s]   = hd_reg[s-1];
                assign sd_src[s]   = sd_reg[s-1];
                assign grey_src[s] = grey_reg[s-1];
                assign adv[s]      = v_reg[s-1] && free[s];
            end

            // downstream take
            if (s == HQW - 1)
            begin : g_last
                assign drain[s] = out_load;
            end
            else
            begin : g_mid
                assign drain[s] = adv[s+1];
            end

            assign free[s] = !v_reg[s] || drain[s];

            // hue quotient bit
            always_comb
            begin
                hds       = HNUM_W'(hd_src[s]) << K;
                hbit      = (hrem_src[s] >= hds);
                hrem_next = hbit ? (hrem_src[s] - hds) : hrem_src[s];
                hq_next   = {hq_src[s][HQW-2:0], hbit};
            end

            // saturation quotient bit in the last stages
            if (s >= SAT_FIRST)
            begin : g_sat
                localparam int KS = HQW - 1 - s;
                logic [SNUM_W-1:0] sds;
                logic              sbit;

                always_comb
                begin
                    sds       = SNUM_W'(sd_src[s]) << KS;
                    sbit      = (srem_src[s] >= sds);
                    srem_next = sbit ? (srem_src[s] - sds) : srem_src[s];
                    sq_next   = {sq_src[s][SAT_QW-2:0], sbit};
                end
            end
            else
            begin : g_nosat
                assign srem_next = srem_src[s];
                assign sq_next   = sq_src[s];
            end

            // stage valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (adv[s])
                begin
                    v_reg[s] <= 1'b1;
                end
                else if (drain[s])
                begin
                    v_reg[s] <= 1'b0;
                end
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    hrem_reg[s] <= hrem_next;
                    hq_reg[s]   <= hq_next;
                    srem_reg[s] <= srem_next;
                    sq_reg[s]   <= sq_next;
                    hd_reg[s]   <= hd_src[s];
                    sd_reg[s]   <= sd_src[s];
                    grey_reg[s] <= grey_src[s];
                end
            end
        end
    endgenerate

    // final wrap and special cases
    always_comb
    begin
        hue_q = hq_reg[HQW-1];
        if (grey_reg[HQW-1] || hue_q == HUE_FULL)
        begin
            hue_q = '0;
        end
        hue_x               = HX_W'(hue_q);
        out_next.hue        = hue_x[HUE_W-1:0];
        out_next.saturation = (sd_reg[HQW-1] == '0) ? '0 : sq_reg[HQW-1];
        out_next.brightness = sd_reg[HQW-1];
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= v_reg[HQW-1];
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign hsv       = out_reg;
    assign hsv_valid = out_valid_reg;

endmodule

### rtl/rgb_to_hsv_converter_unit.sv
// Path from pixel accept to hsv word valid: the front register loads on the accept edge,
// then one queue slot, 9 + HUE_FRAC_BITS divider stages and one output register follow.
// Throughput: one pixel per cycle while hsv_ready does not stall the output; each divider
// stage resolves one hue quotient bit, and each of the last SAT_QW stages also one saturation
// bit, so the divider pipeline depth sets latency and not rate.
// Reset: rst_n clears all valid flags and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Pixel stream converter from 8-bit rgb to hue, saturation and value.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit
    import rhc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pixel_word_t pixel,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    output hsv_word_t   hsv,
    output logic        hsv_valid,
    input  logic        hsv_ready
);

    localparam int HNUM_W = T_W + HUE_FRAC_BITS;
    localparam int Q_W    = HNUM_W + $bits(div_info_t);

    logic [HNUM_W-1:0] f_hue_num;
    div_info_t         f_info;
    logic              f_valid;
    logic              f_ready;

    logic [Q_W-1:0]    q_data;
    logic              q_valid;
    logic              q_ready;
    logic [HNUM_W-1:0] b_hue_num;
    div_info_t         b_info;

    // classifier
    rhc_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .hue_num     (f_hue_num),
        .info        (f_info),
        .info_valid  (f_valid),
        .info_ready  (f_ready)
    );

    // decoupling queue
    rhc_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  ({f_hue_num, f_info}),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    assign b_hue_num = q_data[Q_W-1:$bits(div_info_t)];
    assign b_info    = div_info_t'(q_data[$bits(div_info_t)-1:0]);

    // divider pipeline
    rhc_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hue_num    (b_hue_num),
        .info       (b_info),
        .info_valid (q_valid),
        .info_ready (q_ready),
        .hsv        (hsv),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready)
    );

endmodule
